// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Types and codes shared by the sorted list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned S_DATA_W = 40;  // op + value, padded to bytes
    localparam int unsigned M_DATA_W = 16;  // result fields, padded to bytes

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_RESOLVE,
        S_INS_SHIFT,
        S_INS_WR,
        S_REM_SHIFT,
        S_REM_WR,
        S_DONE
    } t_state;

endpackage

// ===== design/sorted_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine_core
// Bounded ascending multiset of signed keys held in one synchronous RAM,
// with insert, search and remove by a linear scan and a shift sequencer.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake               | Payload
// s       | in  | i_s_tvalid / o_s_tready | i_s_tdata: op, value
// m       | out | o_m_tvalid / i_m_tready | o_m_tdata: found, position, status,
//         |     |                         |            entry_count, is_empty
//
// Each operation scans the stored entries in order up to the first one not
// below the key; insert and remove then shift the entries behind that position.
// Scan and shift together cover at most the stored count, so the worst case
// grows with CAPACITY. The pace is set by the single RAM read port and its
// registered read data.
// One item is in work at a time; the next is taken while a result waits.
// Reset clears the state, the count and the output valid; RAM contents need no clearing.
// A stalled output holds the finished item in the sequencer until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_engine_core #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [1:0] op, [33:2] value, [39:34] zero
    input  logic [sle_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] found, [5:1] position, [7:6] status, [13:8] entry_count,
    // [14] is_empty, [15] zero
    output logic [sle_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import sle_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] mem [CAPACITY];

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_at, n_at;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_match, n_match;
    logic              r_found, n_found;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;
    logic [KEY_W-1:0]  r_rd_data;

    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [KEY_W-1:0]  mem_wdata;

    logic              s_accept;
    logic              out_free;
    logic              is_full;
    logic              hit_ge;
    logic              hit_eq;
    t_op               in_op;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign is_full  = (r_count == CW'(CAPACITY));
    assign hit_ge   = ($signed(r_rd_data) >= $signed(r_key));
    assign hit_eq   = (r_rd_data == r_key);
    assign in_op    = t_op'(i_s_tdata[OP_W-1:0]);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if ((in_op == OP_INSERT && is_full) || in_op == OP_NONE) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_state = (r_idx == r_count) ? S_RESOLVE : S_CMP;
            end
            S_CMP: begin
                n_state = hit_ge ? S_RESOLVE : S_SCAN;
            end
            S_RESOLVE: begin
                case (r_op)
                    OP_INSERT: n_state = S_INS_SHIFT;
                    OP_REMOVE: n_state = r_match ? S_REM_SHIFT : S_DONE;
                    default:   n_state = S_DONE;
                endcase
            end
            S_INS_SHIFT: begin
                n_state = (r_ptr == r_at) ? S_DONE : S_INS_WR;
            end
            S_INS_WR: begin
                n_state = S_INS_SHIFT;
            end
            S_REM_SHIFT: begin
                n_state = ((r_ptr + CW'(1)) >= r_count) ? S_DONE : S_REM_WR;
            end
            S_REM_WR: begin
                n_state = S_REM_SHIFT;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs, RAM control and datapath next values
    always_comb begin
        o_s_tready  = (r_state == S_IDLE);
        mem_re      = 1'b0;
        mem_raddr   = r_idx[AW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = r_ptr[AW-1:0];
        mem_wdata   = r_rd_data;
        n_op        = r_op;
        n_key       = r_key;
        n_count     = r_count;
        n_idx       = r_idx;
        n_at        = r_at;
        n_ptr       = r_ptr;
        n_match     = r_match;
        n_found     = r_found;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op     = in_op;
                    n_key    = i_s_tdata[OP_W +: KEY_W];
                    n_idx    = '0;
                    n_at     = '0;
                    n_match  = 1'b0;
                    n_found  = 1'b0;
                    n_status = (in_op == OP_INSERT && is_full) ? ST_FULL : ST_DONE;
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_at = r_idx;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_CMP: begin
                if (hit_ge) begin
                    n_at    = r_idx;
                    n_match = hit_eq;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_RESOLVE: begin
                case (r_op)
                    OP_INSERT: begin
                        n_ptr = r_count;
                    end
                    OP_SEARCH, OP_REMOVE: begin
                        n_found  = r_match;
                        n_status = r_match ? ST_DONE : ST_NOT_FOUND;
                        n_ptr    = r_at;
                        if (!r_match) begin
                            n_at = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS_SHIFT: begin
                if (r_ptr == r_at) begin
                    // drop the new key into the gap
                    mem_we    = 1'b1;
                    mem_wdata = r_key;
                    n_count   = r_count + CW'(1);
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_ptr - CW'(1));
                end
            end
            S_INS_WR: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr - CW'(1);
            end
            S_REM_SHIFT: begin
                if ((r_ptr + CW'(1)) >= r_count) begin
                    n_count = r_count - CW'(1);
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_ptr + CW'(1));
                end
            end
            S_REM_WR: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + CW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, (r_count == '0), COUNT_W'(r_count), r_status,
                                   POS_W'(r_at), r_found};
                end
            end
            default: begin
            end
        endcase
    end

    // Reads and writes never target the same entry in one cycle: the
    // sequencer always waits for read data before writing it back.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_at       <= n_at;
        r_ptr      <= n_ptr;
        r_match    <= n_match;
        r_found    <= n_found;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count above capacity");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_INS_SHIFT || r_state == S_INS_WR || r_state == S_REM_WR))
        else $error("RAM write outside a shift state");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && in_op == OP_INSERT && is_full)
            |=> (r_state == S_DONE && r_count == $past(r_count)))
        else $error("insert into full store not dropped");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_FULL) |-> is_full)
        else $error("full status reported with free space");

endmodule

// ===== tb/sv/sorted_list_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine_core_test
// Self-checking bench for the sorted list engine. Insert, search and remove
// items go in on the slave stream; an in-bench copy of the sorted store works
// out each result, which is compared field by field with what comes out of
// the master stream. Both sides idle at random, and one long output hold-off
// makes the block stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_engine_core_test;

    import sle_pkg::*;

    localparam int unsigned CAPACITY        = 32;
    localparam int          RESET_CYCLES    = 12;
    localparam int          RANDOM_ITEMS    = 420;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          DRAIN_CYCLES    = 4 * CAPACITY + 40;
    localparam int          WATCHDOG_LIMIT  = 5000;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } list_result_t;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    // in-bench copy of the store, ascending in slots 0..model_count-1
    logic signed [KEY_W-1:0] model_keys [CAPACITY];
    int                      model_count = 0;

    list_result_t list_results_due[$];

    bit sender_burst     = 1'b0;
    bit receiver_burst   = 1'b0;
    bit hold_off_pending = 1'b0;

    int error_count     = 0;
    int results_checked = 0;
    int full_drops      = 0;
    int misses          = 0;
    int op_tally [4]    = '{default: 0};

    sorted_list_engine_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one operation to the local store and return the result it gives.
    function automatic list_result_t predict_list_op(t_op op, logic signed [KEY_W-1:0] key);
        list_result_t r;
        int at;
        r        = '0;
        r.status = ST_DONE;
        case (op)
            OP_INSERT: begin
                if (model_count >= CAPACITY) begin
                    r.status = ST_FULL;
                    full_drops++;
                end else begin
                    at = 0;
                    for (int i = 0; i < model_count; i++) begin
                        if (model_keys[i] < key) at++;
                    end
                    for (int i = model_count; i > at; i--) model_keys[i] = model_keys[i-1];
                    model_keys[at] = key;
                    model_count++;
                    r.position = POS_W'(at);
                end
            end
            OP_SEARCH, OP_REMOVE: begin
                at = model_count;
                for (int i = model_count - 1; i >= 0; i--) begin
                    if (model_keys[i] == key) at = i;
                end
                if (at >= model_count) begin
                    r.status = ST_NOT_FOUND;
                    misses++;
                end else begin
                    r.found    = 1'b1;
                    r.position = POS_W'(at);
                    if (op == OP_REMOVE) begin
                        for (int i = at; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
                        model_count--;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_W'(model_count);
        r.is_empty    = (model_count == 0);
        return r;
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Stored keys, a small pool of close values, the signed extremes, or noise.
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && model_count > 0) begin
            k = model_keys[$urandom_range(0, model_count - 1)];
        end else if (roll < 70) begin
            k = $urandom_range(0, 8);
            k = k - 32'sd4;
        end else if (roll < 85) begin
            case ($urandom_range(0, 5))
                0:       k = KEY_MIN;
                1:       k = KEY_MIN + 32'sd1;
                2:       k = KEY_MAX;
                3:       k = KEY_MAX - 32'sd1;
                4:       k = -32'sd1;
                default: k = '0;
            endcase
        end else begin
            k = $urandom();
        end
        return k;
    endfunction

    // Offer one item and hold it until taken; valid stays high for a back-to-back item.
    task automatic send_item(t_op op, logic signed [KEY_W-1:0] key);
        int gap;
        gap = draw_gap(sender_burst);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W-KEY_W-OP_W){1'b0}}, key, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        op_tally[op]++;
        list_results_due.push_back(predict_list_op(op, key));
    endtask

    task automatic test_empty_store();
        send_item(OP_SEARCH, '0);
        send_item(OP_REMOVE, KEY_MIN);
        send_item(OP_NONE, '1);
    endtask

    task automatic test_extremes_and_duplicates();
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_INSERT, KEY_MIN);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_INSERT, 32'sd1);
        // equal keys go in front of their equals
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_SEARCH, '0);
        send_item(OP_SEARCH, KEY_MAX);
        send_item(OP_SEARCH, KEY_MIN);
        send_item(OP_SEARCH, 32'sd2);
        send_item(OP_SEARCH, KEY_MIN + 32'sd1);
        send_item(OP_REMOVE, '0);
        send_item(OP_REMOVE, '0);
        send_item(OP_REMOVE, '0);
        send_item(OP_NONE, KEY_MIN);
        send_item(OP_REMOVE, KEY_MAX);
        send_item(OP_REMOVE, KEY_MAX);
        send_item(OP_REMOVE, KEY_MIN);
        send_item(OP_REMOVE, -32'sd1);
        send_item(OP_REMOVE, 32'sd1);
    endtask

    task automatic test_fill_to_capacity();
        while (model_count < CAPACITY) send_item(OP_INSERT, pick_key());
        send_item(OP_INSERT, KEY_MIN);
        send_item(OP_INSERT, KEY_MAX);
        send_item(OP_INSERT, pick_key());
        send_item(OP_SEARCH, model_keys[CAPACITY-1]);
        send_item(OP_SEARCH, pick_key());
        // drain in random order, with the odd search in between
        while (model_count > 0) begin
            if ($urandom_range(0, 4) == 0) send_item(OP_SEARCH, pick_key());
            else send_item(OP_REMOVE, model_keys[$urandom_range(0, model_count - 1)]);
        end
    endtask

    task automatic test_output_hold_off();
        sender_burst     = 1'b1;
        hold_off_pending = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_item(($urandom_range(0, 2) == 0) ? OP_SEARCH : OP_INSERT, pick_key());
        end
        sender_burst = 1'b0;
    endtask

    task automatic test_random_mix(int n_items);
        int mode;
        int roll;
        t_op op;
        mode = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                mode           = $urandom_range(0, 2);
                sender_burst   = ($urandom_range(0, 3) == 0);
                receiver_burst = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = OP_NONE;
            end else begin
                case (mode)
                    0:       op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_SEARCH : OP_REMOVE;
                    1:       op = (roll < 25) ? OP_INSERT : (roll < 50) ? OP_SEARCH : OP_REMOVE;
                    default: op = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_SEARCH : OP_REMOVE;
                endcase
            end
            send_item(op, pick_key());
        end
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
    endtask

    // Result side: stall before each item, once for a long stretch on request.
    initial begin : result_receiver
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_gap(receiver_burst);
            if (hold_off_pending) begin
                stall            = HOLD_OFF_CYCLES;
                hold_off_pending = 1'b0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        list_result_t got;
        list_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.found       = o_m_tdata[0];
            got.position    = o_m_tdata[5:1];
            got.status      = t_status'(o_m_tdata[7:6]);
            got.entry_count = o_m_tdata[13:8];
            got.is_empty    = o_m_tdata[14];
            if (list_results_due.size() == 0) begin
                $error("result with nothing outstanding: tdata 0x%04h", o_m_tdata);
                error_count++;
            end else begin
                want = list_results_due.pop_front();
                results_checked++;
                if (got.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    error_count++;
                end
                if (got.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, got.position);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, got.entry_count);
                    error_count++;
                end
                if (got.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                    error_count++;
                end
            end
        end
    end

    // End the run when neither side has moved an item for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, list_results_due.size());
        $display("** sorted_list_engine_core: FAILED **");
        $finish;
    end

    initial begin : run_tests
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_store();
        test_extremes_and_duplicates();
        test_fill_to_capacity();
        test_output_hold_off();
        test_random_mix(RANDOM_ITEMS);
        test_fill_to_capacity();
        i_s_tvalid <= 1'b0;
        while (list_results_due.size() != 0) @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("items in: %0d insert, %0d search, %0d remove, %0d unused op",
                 op_tally[OP_INSERT], op_tally[OP_SEARCH], op_tally[OP_REMOVE],
                 op_tally[OP_NONE]);
        $display("results checked: %0d, inserts dropped when full: %0d, keys not found: %0d",
                 results_checked, full_drops, misses);
        if (error_count == 0) begin
            $display("** sorted_list_engine_core: PASSED **");
        end else begin
            $display("** sorted_list_engine_core: FAILED **");
        end
        $finish;
    end

endmodule
